/* design/lcwd_pkg.sv */
// Package for the line crossing window detector.
// Widths, register indexes, reset values and the structs passed between modules.
// No dependencies.
package lcwd_pkg;

    localparam int WINDOW     = 5;
    localparam int TIME_W     = 32;
    localparam int ONES_W     = 6;
    localparam int TOTAL_W    = 16;
    localparam int THR_W      = 6;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF       = 1'b1;

    localparam logic [THR_W-1:0]  THR_RESET  = 6'd3;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

    typedef struct packed {
        logic [THR_W-1:0]  thr;
        logic [HOLD_W-1:0] holdoff;
    } lcwd_cfg_t;

    typedef struct packed {
        logic              step;
        logic [TIME_W-1:0] now;
        logic              sample;
    } lcwd_in_t;

    typedef struct packed {
        logic               found;
        logic [TOTAL_W-1:0] total;
    } lcwd_res_t;

endpackage

/* design/lcwd_cell.sv */
// One cell of the sample window: holds one bit, passes it on each step.
// Depends on nothing but the clock and reset.
module lcwd_cell (
    input  logic aclk,
    input  logic aresetn,
    input  logic step,
    input  logic clear,
    input  logic d_in,
    output logic q
);

    logic q_reg;
    logic q_next;

    always_comb begin
        q_next = q_reg;
        if (step) begin
            q_next = clear ? 1'b0 : d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= 1'b0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* design/lcwd_chan.sv */
// One detector channel: a chain of window cells, ones count, hold-off and total.
// Depends on lcwd_pkg and lcwd_cell.
module lcwd_chan (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcwd_pkg::lcwd_cfg_t cfg,
    input  lcwd_pkg::lcwd_in_t  in,
    output lcwd_pkg::lcwd_res_t res
);

    logic [lcwd_pkg::WINDOW-1:0]  win;
    logic [lcwd_pkg::WINDOW-1:0]  cell_d;
    logic [lcwd_pkg::ONES_W-1:0]  ones_reg, ones_next, ones_shift;
    logic                         ready_reg, ready_next;
    logic [lcwd_pkg::TIME_W-1:0]  start_reg, start_next;
    logic [lcwd_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [lcwd_pkg::TIME_W-1:0]  elapsed;
    logic                         entered;
    logic                         dropped;
    logic                         found;

    assign entered = ready_reg & in.sample;
    assign dropped = win[lcwd_pkg::WINDOW-1];

    // newest bit enters cell 0, each cell hands its bit to the next
    always_comb begin
        cell_d[0] = entered;
        for (int i = 1; i < lcwd_pkg::WINDOW; i++) begin
            cell_d[i] = win[i-1];
        end
    end

    for (genvar g = 0; g < lcwd_pkg::WINDOW; g++) begin : g_cell
        lcwd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (in.step),
            .clear   (found),
            .d_in    (cell_d[g]),
            .q       (win[g])
        );
    end

    assign ones_shift = ones_reg + {{(lcwd_pkg::ONES_W-1){1'b0}}, entered}
                                 - {{(lcwd_pkg::ONES_W-1){1'b0}}, dropped};
    assign found   = (ones_shift == cfg.thr);
    assign elapsed = in.now - start_reg;

    always_comb begin
        ones_next  = ones_shift;
        ready_next = ready_reg;
        start_next = start_reg;
        total_next = total_reg;
        if (elapsed > {{(lcwd_pkg::TIME_W-lcwd_pkg::HOLD_W){1'b0}}, cfg.holdoff}) begin
            ready_next = 1'b1;
        end
        if (found) begin
            ones_next  = '0;
            ready_next = 1'b0;
            start_next = in.now;
            if (total_reg != {lcwd_pkg::TOTAL_W{1'b1}}) begin
                total_next = total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ones_reg  <= '0;
            ready_reg <= 1'b1;
            start_reg <= '0;
            total_reg <= '0;
        end else if (in.step) begin
            ones_reg  <= ones_next;
            ready_reg <= ready_next;
            start_reg <= start_next;
            total_reg <= total_next;
        end
    end

    assign res.found = found;
    assign res.total = total_next;

    a_ones_tracks_window: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(win) == 32'(ones_reg))
        else $error("ones count does not match window contents");

    a_found_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in.step && found |=> ones_reg == '0 && !ready_reg && win == '0)
        else $error("detection did not clear window and ready");

    a_total_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        in.step && found && total_reg != {lcwd_pkg::TOTAL_W{1'b1}}
        |=> total_reg == $past(total_reg) + 1'b1)
        else $error("total did not advance on detection");

endmodule

/* design/line_crossing_window_detector_unit.sv */
// Line crossing window detector, top level.
// Config registers, two lcwd_chan channels and the output register with skid stage.
// Depends on lcwd_pkg, lcwd_chan.
//
// Usage: one sample transaction on s_ (timestamp plus left and right sensor
// bits) gives exactly one result transaction on m_ (found flags and running
// totals per channel). Both channels update in the cycle the sample is taken;
// each holds its window as a chain of one-bit cells that shift by one per
// sample, so the ones count, hold-off test and detection all finish in that
// cycle.
// Output: the result is registered, in the skid stage if the output register is held.
// Throughput: one sample per cycle, sustained while m_tready stays high.
// Stall: an output register plus a one-entry skid stage; s_tready drops only
// when both hold results, and no result is lost or repeated.
// Reset (aresetn low, synchronous): windows, counts and totals clear, both
// channels come up ready, registers return to threshold 3 and hold-off 1000.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 threshold,
// 1 hold-off); write only while no transaction is in flight.
module line_crossing_window_detector_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] now_ms, [32] left_bit, [33] right_bit, [39:34] zero
    input  logic [lcwd_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] left_found, [1] right_found, [17:2] left_total, [33:18] right_total,
    // [39:34] zero
    output logic [lcwd_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [lcwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcwd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    lcwd_pkg::lcwd_cfg_t cfg_reg, cfg_next;
    lcwd_pkg::lcwd_in_t  left_in, right_in;
    lcwd_pkg::lcwd_res_t left_res, right_res;

    logic                          accept;
    logic                          pop;
    logic [lcwd_pkg::M_DATA_W-1:0] new_data;
    logic                          out_valid_reg, out_valid_next;
    logic [lcwd_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                          skid_valid_reg, skid_valid_next;
    logic [lcwd_pkg::M_DATA_W-1:0] skid_data_reg, skid_data_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                lcwd_pkg::REG_HIT_THRESHOLD: cfg_next.thr     = cfg_wdata[lcwd_pkg::THR_W-1:0];
                lcwd_pkg::REG_HOLDOFF:       cfg_next.holdoff = cfg_wdata[lcwd_pkg::HOLD_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thr     <= lcwd_pkg::THR_RESET;
            cfg_reg.holdoff <= lcwd_pkg::HOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    assign left_in.step    = accept;
    assign left_in.now     = s_tdata[31:0];
    assign left_in.sample  = s_tdata[32];
    assign right_in.step   = accept;
    assign right_in.now    = s_tdata[31:0];
    assign right_in.sample = s_tdata[33];

    lcwd_chan u_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in      (left_in),
        .res     (left_res)
    );

    lcwd_chan u_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in      (right_in),
        .res     (right_res)
    );

    assign new_data = {6'b0, right_res.total, left_res.total,
                       right_res.found, left_res.found};

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = new_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = new_data;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_found_has_total: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[0] |-> out_data_reg[17:2] != '0)
        else $error("left crossing reported with zero total");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

endmodule
